>>> rtl/vbh_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vbh_pkg
// Shared constants for the variable width bin histogram: command codes,
// count width and default sizes.
// ----------------------------------------------------------------------------
package vbh_pkg;

  localparam int NUM_BINS_DEF = 32;
  localparam int CNT_W        = 32;
  localparam int VAL_W        = 32;
  localparam int CMD_W        = 3;
  localparam int IDX_W        = 6;
  localparam int BIN_OUT_W    = 5;
  localparam int CFG_W        = 6;

  localparam logic [CFG_W-1:0] BINS_RESET = 6'd32;
  localparam logic [CNT_W-1:0] ONE_EVENT  = 32'h0000_0100;
  localparam logic [CNT_W-1:0] CNT_MAX    = 32'hFFFF_FFFF;

  localparam logic [CMD_W-1:0] CMD_SAMPLE     = 3'd0;
  localparam logic [CMD_W-1:0] CMD_WRITE_EDGE = 3'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR      = 3'd2;
  localparam logic [CMD_W-1:0] CMD_RESCALE    = 3'd3;
  localparam logic [CMD_W-1:0] CMD_ADD        = 3'd4;
  localparam logic [CMD_W-1:0] CMD_READ       = 3'd5;

endpackage

>>> rtl/variable_bin_histogram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// variable_bin_histogram
// Histogram with bins of varying width. Edges and counts live in two
// memories; a sequencer searches edges, walks the bins and does
// read-modify-write updates of single counts.
//
// channel  ports                                         handshake
// input    in_cmd in_sample_value in_entry_index         start && !busy
//          in_scale_weight in_add_amount
// result   out_in_range out_found_bin out_bin_value      out_valid, one cycle
// config   cfg_data                                      cfg_we
//
// sample: busy while edges are searched (one edge read per cycle) until a hit in bin i
//   or, on a miss with n active bins, until all n bins are passed
// write edge is never busy; clear and rescale each walk all NUM_BINS counts
// result strobe follows in the cycle after the last busy cycle
// after reset all NUM_BINS counts are swept to zero, busy
// the receiver cannot stall; results are never held back
// ----------------------------------------------------------------------------
module variable_bin_histogram #(
  parameter int NUM_BINS = vbh_pkg::NUM_BINS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [vbh_pkg::CMD_W-1:0]      in_cmd,
  input  logic signed [vbh_pkg::VAL_W-1:0] in_sample_value,
  input  logic [vbh_pkg::IDX_W-1:0]      in_entry_index,
  input  logic [vbh_pkg::CNT_W-1:0]      in_scale_weight,
  input  logic [vbh_pkg::CNT_W-1:0]      in_add_amount,
  input  logic                           cfg_we,
  input  logic [vbh_pkg::CFG_W-1:0]      cfg_data,
  output logic                           out_valid,
  output logic                           out_in_range,
  output logic [vbh_pkg::BIN_OUT_W-1:0]  out_found_bin,
  output logic [vbh_pkg::CNT_W-1:0]      out_bin_value
);

  localparam int EA = $clog2(NUM_BINS + 1);
  localparam int CA = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
  localparam logic [15:0]   NB16 = 16'(NUM_BINS);
  localparam logic [CA-1:0] LAST = CA'(NUM_BINS - 1);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SEARCH = 5'b00010,
    S_UPDATE = 5'b00100,
    S_CLEAR  = 5'b01000,
    S_SCALE  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  logic [vbh_pkg::CFG_W-1:0] bins_r;
  logic [vbh_pkg::VAL_W-1:0] val_r, val_nxt;
  logic [vbh_pkg::CNT_W-1:0] weight_r, weight_nxt;
  logic [vbh_pkg::CNT_W-1:0] add_val_r, add_val_nxt;
  logic [vbh_pkg::VAL_W-1:0] prev_r, prev_nxt;
  logic [2*vbh_pkg::CNT_W-1:0] prod_r, prod_nxt;
  logic                      hit_flag_r, hit_flag_nxt;
  logic [EA-1:0]             ek_r, ek_nxt;
  logic [CA-1:0]             bin_r, bin_nxt;
  logic [CA-1:0]             cnt_r, cnt_nxt;
  logic [CA-1:0]             rd_r, rd_nxt;
  logic [CA-1:0]             a1_r, a1_nxt;
  logic [CA-1:0]             a2_r, a2_nxt;
  logic                      rd_on_r, rd_on_nxt;
  logic                      v1_r, v1_nxt;
  logic                      v2_r, v2_nxt;
  logic                      report_r, report_nxt;

  logic                          out_valid_r, out_valid_nxt;
  logic                          out_in_range_r, out_in_range_nxt;
  logic [vbh_pkg::BIN_OUT_W-1:0] out_found_bin_r, out_found_bin_nxt;
  logic [vbh_pkg::CNT_W-1:0]     out_bin_value_r, out_bin_value_nxt;

  logic                      e_we;
  logic [EA-1:0]             e_waddr, e_raddr;
  logic [vbh_pkg::VAL_W-1:0] e_wdata, e_rdata;
  logic                      c_we;
  logic [CA-1:0]             c_waddr, c_raddr;
  logic [vbh_pkg::CNT_W-1:0] c_wdata, c_rdata;

  logic [vbh_pkg::CNT_W-1:0]   sum_sat, scale_sat;
  logic [2*vbh_pkg::CNT_W-1:0] mul_prod;

  logic [15:0]   idx16;
  logic [15:0]   n16;
  logic [EA-1:0] n_ea;
  logic [EA-1:0] ek_m1;
  logic [15:0]   bin16;
  logic          in_bin;

  assign idx16 = 16'(in_entry_index);
  assign n16   = (16'(bins_r) > NB16) ? NB16 : 16'(bins_r);
  assign n_ea  = n16[EA-1:0];
  assign ek_m1 = ek_r - EA'(1);
  assign bin16 = 16'(bin_r);
  assign in_bin = ($signed(val_r) >= $signed(prev_r)) && ($signed(val_r) < $signed(e_rdata));

  vbh_ram #(.WIDTH(vbh_pkg::VAL_W), .DEPTH(NUM_BINS + 1)) u_edge_ram (
    .clk   (clk),
    .we    (e_we),
    .waddr (e_waddr),
    .wdata (e_wdata),
    .raddr (e_raddr),
    .rdata (e_rdata)
  );

  vbh_ram #(.WIDTH(vbh_pkg::CNT_W), .DEPTH(NUM_BINS)) u_count_ram (
    .clk   (clk),
    .we    (c_we),
    .waddr (c_waddr),
    .wdata (c_wdata),
    .raddr (c_raddr),
    .rdata (c_rdata)
  );

  vbh_alu u_alu (
    .add_a    (c_rdata),
    .add_b    (add_val_r),
    .add_sum  (sum_sat),
    .mul_a    (c_rdata),
    .mul_b    (weight_r),
    .mul_prod (mul_prod),
    .prod_in  (prod_r),
    .scaled   (scale_sat)
  );

  assign busy          = (state_r != S_IDLE);
  assign out_valid     = out_valid_r;
  assign out_in_range  = out_in_range_r;
  assign out_found_bin = out_found_bin_r;
  assign out_bin_value = out_bin_value_r;

  always_comb begin
    state_nxt    = state_r;
    val_nxt      = val_r;
    weight_nxt   = weight_r;
    add_val_nxt  = add_val_r;
    prev_nxt     = prev_r;
    prod_nxt     = mul_prod;
    hit_flag_nxt = hit_flag_r;
    ek_nxt       = ek_r;
    bin_nxt      = bin_r;
    cnt_nxt      = cnt_r;
    rd_nxt       = rd_r;
    a1_nxt       = rd_r;
    a2_nxt       = a1_r;
    rd_on_nxt    = rd_on_r;
    v1_nxt       = 1'b0;
    v2_nxt       = v1_r;
    report_nxt   = report_r;

    out_valid_nxt     = 1'b0;
    out_in_range_nxt  = 1'b0;
    out_found_bin_nxt = '0;
    out_bin_value_nxt = '0;

    e_we    = 1'b0;
    e_waddr = idx16[EA-1:0];
    e_wdata = in_sample_value;
    e_raddr = '0;
    c_we    = 1'b0;
    c_waddr = bin_r;
    c_wdata = sum_sat;
    c_raddr = idx16[CA-1:0];

    case (state_r)
      S_IDLE: begin
        if (start) begin
          case (in_cmd)
            vbh_pkg::CMD_SAMPLE: begin
              val_nxt = in_sample_value;
              ek_nxt  = '0;
              if (n16 == 16'd0) begin
                out_valid_nxt = 1'b1;
              end else begin
                state_nxt = S_SEARCH;
              end
            end
            vbh_pkg::CMD_WRITE_EDGE: begin
              e_we          = (idx16 <= NB16);
              out_valid_nxt = 1'b1;
            end
            vbh_pkg::CMD_CLEAR: begin
              cnt_nxt    = '0;
              report_nxt = 1'b1;
              state_nxt  = S_CLEAR;
            end
            vbh_pkg::CMD_RESCALE: begin
              weight_nxt = in_scale_weight;
              rd_nxt     = '0;
              rd_on_nxt  = 1'b1;
              v2_nxt     = 1'b0;
              state_nxt  = S_SCALE;
            end
            vbh_pkg::CMD_ADD, vbh_pkg::CMD_READ: begin
              if (idx16 < NB16) begin
                bin_nxt      = idx16[CA-1:0];
                add_val_nxt  = (in_cmd == vbh_pkg::CMD_ADD) ? in_add_amount : '0;
                hit_flag_nxt = 1'b0;
                state_nxt    = S_UPDATE;
              end else begin
                out_valid_nxt = 1'b1;
              end
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end
      S_SEARCH: begin
        e_raddr = (ek_r != n_ea) ? ek_r + EA'(1) : ek_r;
        c_raddr = ek_m1[CA-1:0];
        if (ek_r == '0) begin
          prev_nxt = e_rdata;
          ek_nxt   = ek_r + EA'(1);
        end else if (in_bin) begin
          bin_nxt      = ek_m1[CA-1:0];
          add_val_nxt  = vbh_pkg::ONE_EVENT;
          hit_flag_nxt = 1'b1;
          state_nxt    = S_UPDATE;
        end else if (ek_r == n_ea) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          prev_nxt = e_rdata;
          ek_nxt   = ek_r + EA'(1);
        end
      end
      S_UPDATE: begin
        c_we              = 1'b1;
        c_waddr           = bin_r;
        c_wdata           = sum_sat;
        out_valid_nxt     = 1'b1;
        out_in_range_nxt  = hit_flag_r;
        out_found_bin_nxt = bin16[vbh_pkg::BIN_OUT_W-1:0];
        out_bin_value_nxt = sum_sat;
        state_nxt         = S_IDLE;
      end
      S_CLEAR: begin
        c_we    = 1'b1;
        c_waddr = cnt_r;
        c_wdata = '0;
        if (cnt_r == LAST) begin
          out_valid_nxt = report_r;
          report_nxt    = 1'b0;
          state_nxt     = S_IDLE;
        end else begin
          cnt_nxt = cnt_r + CA'(1);
        end
      end
      S_SCALE: begin
        c_raddr = rd_r;
        if (rd_on_r) begin
          v1_nxt = 1'b1;
          if (rd_r == LAST) begin
            rd_on_nxt = 1'b0;
          end else begin
            rd_nxt = rd_r + CA'(1);
          end
        end
        if (v2_r) begin
          c_we    = 1'b1;
          c_waddr = a2_r;
          c_wdata = scale_sat;
          if (a2_r == LAST) begin
            out_valid_nxt = 1'b1;
            state_nxt     = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      cnt_r       <= '0;
      report_r    <= 1'b0;
      bins_r      <= vbh_pkg::BINS_RESET;
      rd_on_r     <= 1'b0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      report_r    <= report_nxt;
      rd_on_r     <= rd_on_nxt;
      v1_r        <= v1_nxt;
      v2_r        <= v2_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        bins_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    val_r           <= val_nxt;
    weight_r        <= weight_nxt;
    add_val_r       <= add_val_nxt;
    prev_r          <= prev_nxt;
    prod_r          <= prod_nxt;
    hit_flag_r      <= hit_flag_nxt;
    ek_r            <= ek_nxt;
    bin_r           <= bin_nxt;
    rd_r            <= rd_nxt;
    a1_r            <= a1_nxt;
    a2_r            <= a2_nxt;
    out_in_range_r  <= out_in_range_nxt;
    out_found_bin_r <= out_found_bin_nxt;
    out_bin_value_r <= out_bin_value_nxt;
  end

endmodule

>>> rtl/vbh_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vbh_ram
// Generic memory with one write port and one read port, registered read.
// ----------------------------------------------------------------------------
module vbh_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/vbh_alu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vbh_alu
// Count arithmetic: saturating add, count times weight product, and the
// truncating, saturating Q16.16 rescale of a registered product.
// ----------------------------------------------------------------------------
module vbh_alu (
  input  logic [vbh_pkg::CNT_W-1:0]   add_a,
  input  logic [vbh_pkg::CNT_W-1:0]   add_b,
  output logic [vbh_pkg::CNT_W-1:0]   add_sum,
  input  logic [vbh_pkg::CNT_W-1:0]   mul_a,
  input  logic [vbh_pkg::CNT_W-1:0]   mul_b,
  output logic [2*vbh_pkg::CNT_W-1:0] mul_prod,
  input  logic [2*vbh_pkg::CNT_W-1:0] prod_in,
  output logic [vbh_pkg::CNT_W-1:0]   scaled
);

  logic [vbh_pkg::CNT_W:0] sum_wide;

  assign sum_wide = {1'b0, add_a} + {1'b0, add_b};
  assign add_sum  = sum_wide[vbh_pkg::CNT_W] ? vbh_pkg::CNT_MAX
                                             : sum_wide[vbh_pkg::CNT_W-1:0];

  assign mul_prod = {{vbh_pkg::CNT_W{1'b0}}, mul_a} * {{vbh_pkg::CNT_W{1'b0}}, mul_b};

  // drop 16 fraction bits, saturate if anything remains above bit 47
  assign scaled = (prod_in[63:48] != 16'd0) ? vbh_pkg::CNT_MAX : prod_in[47:16];

endmodule
